// File: hw/rtl/hse_pkg.sv
// Shared types and constants for the Huffman symbol encoder.
package hse_pkg;

   // Fixed field widths
   localparam int KIND_W    = 2;
   localparam int SYM_W     = 8;
   localparam int CODE_IN_W = 32;
   localparam int LEN_W     = 6;
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int TOTAL_W   = 32;
   localparam int PEND_W    = 7;
   localparam int CNT_W     = 3;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DATA    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FINAL   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic load_write;  // write table entry from the request beat
      logic lookup;      // read table entry for the request beat
      logic build;       // append looked-up code to the buffer
      logic emit;        // send one data byte
      logic unknown;     // send the unknown-symbol result
      logic flush;       // send the final byte and clear the buffer
   } hse_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic hit;         // looked-up entry is valid and in range
      logic has_byte;    // build yields at least one full byte
      logic last_byte;   // byte being emitted is the last one
      logic out_free;    // output register can take a result
   } hse_stat_type;

endpackage

// File: hw/rtl/hse_ctrl.sv
// Controller state machine for the Huffman symbol encoder.
module hse_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic [hse_pkg::KIND_W-1:0] req_kind,
   output logic                      req_tready,
   input  hse_pkg::hse_stat_type     stat,
   output hse_pkg::hse_cmd_type      cmd
);
   import hse_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LOOKUP  = 3'd1;
   localparam logic [2:0] ST_EMIT    = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_FLUSH   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_LOAD: begin
                     cmd.load_write = 1'b1;
                  end
                  KIND_ENCODE: begin
                     cmd.lookup = 1'b1;
                     state_in   = ST_LOOKUP;
                  end
                  KIND_FLUSH: begin
                     state_in = ST_FLUSH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (stat.hit) begin
               cmd.build = 1'b1;
               state_in  = stat.has_byte ? ST_EMIT : ST_IDLE;
            end else begin
               state_in = ST_UNKNOWN;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_UNKNOWN: begin
            if (stat.out_free) begin
               cmd.unknown = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // At most one datapath action per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_write, cmd.lookup, cmd.build, cmd.emit, cmd.unknown, cmd.flush}))
      else $error("hse_ctrl: more than one command in a cycle");

   // A table read is always followed by the lookup step
   a_lookup_next: assert property (@(posedge clock) disable iff (reset)
      cmd.lookup |=> (state_ff == ST_LOOKUP))
      else $error("hse_ctrl: lookup not followed by lookup state");

   // Results are only produced while the output register can take them
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.unknown || cmd.flush) |-> stat.out_free)
      else $error("hse_ctrl: result produced while output register is busy");

endmodule

// File: hw/rtl/hse_datapath.sv
// Datapath for the Huffman symbol encoder: code table, bit buffer, output register.
module hse_datapath #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hse_pkg::hse_cmd_type                 cmd,
   output hse_pkg::hse_stat_type                stat,
   input  logic [hse_pkg::SYM_W-1:0]            req_symbol,
   input  logic [hse_pkg::CODE_IN_W-1:0]        req_code_bits,
   input  logic [hse_pkg::LEN_W-1:0]            req_code_length,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [hse_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [hse_pkg::STATUS_W-1:0]         rsp_tuser,
   output logic                                 rsp_tlast
);
   import hse_pkg::*;

   localparam int LEN_CAP = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
   localparam int CODE_W  = LEN_CAP;
   localparam int ENT_W   = LEN_W + CODE_W;
   localparam int ACC_W   = CODE_W + PEND_W;
   localparam int N_W     = $clog2(ACC_W + 1);
   localparam int IDX_W   = $clog2(SYMBOL_COUNT);
   localparam logic [SYM_W:0]  SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_CAP);
   localparam logic [PEND_W-1:0] PEND_ONES = {PEND_W{1'b1}};

   // Table storage and valid bits
   logic [ENT_W-1:0]        table_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0] valid_ff;
   logic [ENT_W-1:0]        rd_entry_ff;
   logic                    hit_ff;

   // Bit buffer
   logic [PEND_W-1:0]  pending_bits_ff;
   logic [CNT_W-1:0]   pending_count_ff;
   logic [TOTAL_W-1:0] bit_total_ff;
   logic [TOTAL_W-1:0] bit_total_in;
   logic [ACC_W-1:0]   acc_ff;
   logic [N_W-1:0]     n_ff;

   // Output register
   logic                rsp_valid_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic                rsp_last_ff;

   logic               in_range;
   logic [IDX_W-1:0]   idx;
   logic [LEN_W-1:0]   len_cl;
   logic [CODE_W-1:0]  wr_code;
   logic [LEN_W-1:0]   clen;
   logic [CODE_W-1:0]  rd_code;
   logic [ACC_W-1:0]   acc_build;
   logic [N_W-1:0]     n_build;
   logic [TOTAL_W:0]   total_sum;
   logic [N_W-1:0]     n_rem;
   logic [ACC_W-1:0]   emit_shift;
   logic [BYTE_W-1:0]  emit_byte;
   logic [BYTE_W-1:0]  flush_byte;
   logic               out_load;

   // Request decode: range check, length clamp, code mask
   assign in_range = ({1'b0, req_symbol} < SYM_LIMIT);
   assign idx      = req_symbol[IDX_W-1:0];
   assign len_cl   = (req_code_length > LEN_LIMIT) ? LEN_LIMIT : req_code_length;
   assign wr_code  = req_code_bits[CODE_W-1:0] & ~({CODE_W{1'b1}} << len_cl);

   // Table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.load_write && in_range && (len_cl != '0)) begin
         table_mem[idx] <= {len_cl, wr_code};
      end
      if (cmd.lookup) begin
         rd_entry_ff <= table_mem[idx];
         hit_ff      <= in_range && valid_ff[idx];
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.load_write && in_range) begin
         valid_ff[idx] <= (len_cl != '0);
      end
   end

   // Append code to the leftover bits
   assign clen      = rd_entry_ff[ENT_W-1 -: LEN_W];
   assign rd_code   = rd_entry_ff[CODE_W-1:0];
   assign acc_build = (ACC_W'(pending_bits_ff) << clen) | ACC_W'(rd_code);
   assign n_build   = N_W'(pending_count_ff) + N_W'(clen);
   assign total_sum = {1'b0, bit_total_ff} + (TOTAL_W + 1)'(clen);
   assign bit_total_in = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

   // Byte extraction, earliest bit first
   assign n_rem      = n_ff - N_W'(BYTE_W);
   assign emit_shift = acc_ff >> n_rem;
   assign emit_byte  = emit_shift[BYTE_W-1:0];
   assign flush_byte = BYTE_W'({1'b0, pending_bits_ff} << (BYTE_W - int'(pending_count_ff)));

   // Buffer and total update
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
         bit_total_ff     <= '0;
      end else if (cmd.build) begin
         pending_bits_ff  <= acc_build[PEND_W-1:0] & ~(PEND_ONES << n_build[CNT_W-1:0]);
         pending_count_ff <= n_build[CNT_W-1:0];
         bit_total_ff     <= bit_total_in;
      end else if (cmd.flush) begin
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
         bit_total_ff     <= '0;
      end
   end

   // Bytes still to send for the current symbol
   always_ff @(posedge clock) begin
      if (cmd.build) begin
         acc_ff <= acc_build;
         n_ff   <= n_build;
      end else if (cmd.emit) begin
         n_ff <= n_rem;
      end
   end

   // Output register
   assign out_load = cmd.emit || cmd.unknown || cmd.flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_byte_ff   <= emit_byte;
         rsp_status_ff <= STATUS_DATA;
         rsp_total_ff  <= bit_total_ff;
         rsp_last_ff   <= (n_rem < N_W'(BYTE_W));
      end else if (cmd.unknown) begin
         rsp_byte_ff   <= '0;
         rsp_status_ff <= STATUS_UNKNOWN;
         rsp_total_ff  <= bit_total_ff;
         rsp_last_ff   <= 1'b1;
      end else if (cmd.flush) begin
         rsp_byte_ff   <= (pending_count_ff != '0) ? flush_byte : '0;
         rsp_status_ff <= (pending_count_ff != '0) ? STATUS_FINAL : STATUS_EMPTY;
         rsp_total_ff  <= bit_total_ff;
         rsp_last_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_total_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Status to the controller
   assign stat.hit       = hit_ff;
   assign stat.has_byte  = (n_build >= N_W'(BYTE_W));
   assign stat.last_byte = (n_rem < N_W'(BYTE_W));
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // Never send a byte from fewer than eight buffered bits
   a_emit_full: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (n_ff >= N_W'(BYTE_W)))
      else $error("hse_datapath: byte emitted from a partial buffer");

   // Flush leaves an empty buffer and a zero total
   a_flush_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> ((pending_count_ff == '0) && (bit_total_ff == '0)))
      else $error("hse_datapath: buffer not cleared by flush");

   // A result never overwrites one that was not taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !out_load)
      else $error("hse_datapath: output register overrun");

endmodule

// File: hw/rtl/huffman_symbol_encoder_top.sv
// Top level of the Huffman symbol encoder: controller plus datapath.
//
//  channel  | direction | tdata (low bit up)                      | tuser    | tlast
//  req_     | in        | symbol 8, code_bits 32, code_length 6   | kind 2   | -
//  rsp_     | out       | out_byte 8, total_bits 32               | status 2 | last_of_run
//
// Load writes the table entry. Encode: table read, append, then one result per output
// byte. Unknown symbol: table read, miss, result. Flush: final result.
// Reset clears the valid bits, the bit buffer and the total at once; the
// table contents stay undefined until written.
// A stalled rsp_ channel holds the controller in its result states; the next
// request beat is taken while the last result still waits in the output register.
module huffman_symbol_encoder_top #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = symbol[7:0], code_bits[39:8], code_length[45:40], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [hse_pkg::REQ_DATA_W-1:0]    req_tdata,
   // request: tuser = kind[1:0]
   input  logic [hse_pkg::KIND_W-1:0]        req_tuser,
   // response: tdata = out_byte[7:0], total_bits[39:8]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hse_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // response: tuser = status[1:0]
   output logic [hse_pkg::STATUS_W-1:0]      rsp_tuser,
   output logic                              rsp_tlast
);
   import hse_pkg::*;

   hse_cmd_type  cmd;
   hse_stat_type stat;

   // Unpack request beat
   logic [SYM_W-1:0]     req_symbol;
   logic [CODE_IN_W-1:0] req_code_bits;
   logic [LEN_W-1:0]     req_code_length;

   assign req_symbol      = req_tdata[SYM_W-1:0];
   assign req_code_bits   = req_tdata[SYM_W +: CODE_IN_W];
   assign req_code_length = req_tdata[SYM_W + CODE_IN_W +: LEN_W];

   hse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hse_datapath #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_symbol      (req_symbol),
      .req_code_bits   (req_code_bits),
      .req_code_length (req_code_length),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast)
   );

endmodule
